>>> rtl/simon_pkg.sv
// ----------------------------------------------------------------------------
// simon_pkg
// shared constants, types and round functions for the simon32/64 encrypt core
// ----------------------------------------------------------------------------
package simon_pkg;

    localparam int NUM_ROUNDS = 32;
    localparam int KEY_WORDS  = 4;
    localparam int WORD_W     = 16;
    localparam int BLOCK_W    = 2 * WORD_W;
    localparam int KEY_W      = KEY_WORDS * WORD_W;
    localparam int ROUND_AW   = $clog2(NUM_ROUNDS);
    localparam int Z_LEN      = 62;
    localparam int Z_AW       = $clog2(Z_LEN);

    // round index of the last round / last key word
    localparam logic [ROUND_AW-1:0] ROUND_LAST = ROUND_AW'(NUM_ROUNDS - 1);

    // key schedule constant, not of (key word xor 3)
    localparam logic [WORD_W-1:0] KS_CONST = 16'hFFFC;

    // z0 sequence, element 0 in bit 0 (period 31, two periods)
    localparam logic [30:0] Z0_PERIOD = 31'b0110011100001101010010001011111;
    localparam logic [Z_LEN-1:0] Z0_SEQ = {Z0_PERIOD, Z0_PERIOD};

    // one write into the round key store
    typedef struct packed {
        logic                we;
        logic [ROUND_AW-1:0] addr;
        logic [WORD_W-1:0]   data;
    } t_key_wr;

    function automatic logic [WORD_W-1:0] rotl(input logic [WORD_W-1:0] v,
                                               input int unsigned n);
        rotl = (v << n) | (v >> (WORD_W - n));
    endfunction

    function automatic logic [WORD_W-1:0] rotr(input logic [WORD_W-1:0] v,
                                               input int unsigned n);
        rotr = (v >> n) | (v << (WORD_W - n));
    endfunction

    // feistel mixing of the left word
    function automatic logic [WORD_W-1:0] round_f(input logic [WORD_W-1:0] x);
        round_f = (rotl(x, 1) & rotl(x, 8)) ^ rotl(x, 2);
    endfunction

endpackage

>>> rtl/simon_key_ram.sv
// ----------------------------------------------------------------------------
// simon_key_ram
// simple dual port ram, one write and one registered read per cycle
// ----------------------------------------------------------------------------
module simon_key_ram #(
    parameter int DEPTH = 32,
    parameter int WIDTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

>>> rtl/simon_key_sched.sv
// ----------------------------------------------------------------------------
// simon_key_sched
// key expansion sequencer, one round key written to the store per cycle
// ----------------------------------------------------------------------------
module simon_key_sched (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic [simon_pkg::KEY_W-1:0] i_key,
    output logic                        o_busy,
    output simon_pkg::t_key_wr          o_wr
);

    logic                                r_busy;
    logic [simon_pkg::ROUND_AW-1:0]      r_cnt;
    // sliding window: r_win[j] holds round key r_cnt + j
    logic [simon_pkg::WORD_W-1:0]        r_win [simon_pkg::KEY_WORDS];
    logic [simon_pkg::WORD_W-1:0]        n_t;
    logic [simon_pkg::WORD_W-1:0]        n_mix;
    logic [simon_pkg::WORD_W-1:0]        n_key;
    logic                                n_z;

    always_comb begin
        n_t   = simon_pkg::rotr(r_win[3], 3) ^ r_win[1];
        n_mix = n_t ^ simon_pkg::rotr(n_t, 1);
        n_z   = simon_pkg::Z0_SEQ[{1'b0, r_cnt}];
        n_key = r_win[0] ^ simon_pkg::KS_CONST ^ n_mix
              ^ {{(simon_pkg::WORD_W-1){1'b0}}, n_z};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= '0;
        end else if (r_busy) begin
            r_cnt <= r_cnt + 1'b1;
            if (r_cnt == simon_pkg::ROUND_LAST) begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            for (int j = 0; j < simon_pkg::KEY_WORDS; j++) begin
                r_win[j] <= i_key[j*simon_pkg::WORD_W +: simon_pkg::WORD_W];
            end
        end else if (r_busy) begin
            r_win[0] <= r_win[1];
            r_win[1] <= r_win[2];
            r_win[2] <= r_win[3];
            r_win[3] <= n_key;
        end
    end

    assign o_busy    = r_busy;
    assign o_wr.we   = r_busy;
    assign o_wr.addr = r_cnt;
    assign o_wr.data = r_win[0];

endmodule

>>> rtl/simon_round.sv
// ----------------------------------------------------------------------------
// simon_round
// feistel round datapath, one round per cycle with the key read from the store
// ----------------------------------------------------------------------------
module simon_round (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_start,
    input  logic [simon_pkg::BLOCK_W-1:0]  i_block,
    input  logic [simon_pkg::WORD_W-1:0]   i_rkey,
    input  logic                           i_take,
    output logic [simon_pkg::ROUND_AW-1:0] o_rd_addr,
    output logic                           o_idle,
    output logic                           o_done,
    output logic [simon_pkg::BLOCK_W-1:0]  o_result
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_RUN  = 2'd1;
    localparam logic [1:0] ST_DONE = 2'd2;

    logic [1:0]                     r_state;
    logic [simon_pkg::ROUND_AW-1:0] r_cnt;
    logic [simon_pkg::WORD_W-1:0]   r_x;
    logic [simon_pkg::WORD_W-1:0]   r_y;
    logic [simon_pkg::WORD_W-1:0]   n_x;

    assign n_x = r_y ^ simon_pkg::round_f(r_x) ^ i_rkey;

    // prefetch the key of the next round; key 0 while idle
    assign o_rd_addr = (r_state == ST_RUN) ? r_cnt + 1'b1 : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_cnt   <= '0;
        end else begin
            case (r_state)
                ST_IDLE: begin
                    if (i_start) begin
                        r_state <= ST_RUN;
                        r_cnt   <= '0;
                    end
                end
                ST_RUN: begin
                    r_cnt <= r_cnt + 1'b1;
                    if (r_cnt == simon_pkg::ROUND_LAST) begin
                        r_state <= ST_DONE;
                    end
                end
                ST_DONE: begin
                    if (i_take) begin
                        r_state <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == ST_IDLE && i_start) begin
            r_x <= i_block[simon_pkg::BLOCK_W-1:simon_pkg::WORD_W];
            r_y <= i_block[simon_pkg::WORD_W-1:0];
        end else if (r_state == ST_RUN) begin
            r_x <= n_x;
            r_y <= r_x;
        end
    end

    assign o_idle   = (r_state == ST_IDLE);
    assign o_done   = (r_state == ST_DONE);
    assign o_result = {r_x, r_y};

endmodule

>>> rtl/simon32_64_block_encrypt_core.sv
// ----------------------------------------------------------------------------
// simon32_64_block_encrypt_core
// simon32/64 block encryption with the round keys held in a small ram
// ----------------------------------------------------------------------------
// usage:
//   key port: i_cfg_we with i_cfg_wdata loads the 64-bit key (bits 15..0 are
//     the first round key); the key schedule then writes 32 round keys into
//     the key ram, one per cycle, once r_kick has started the schedule
//   input stream: s_axis_* carries one plaintext block per request
//   output stream: m_axis_* carries the ciphertext block of each request
//   datapath: an accepted request runs its rounds in the round unit, one
//     round per cycle, each round key read from the key ram in the round
//     before (single read port, registered read); the ciphertext then moves
//     into the output register that drives m_axis_tvalid; the round unit
//     handles one block at a time, taking a new request only once idle
//   reset: the key returns to all zero and the schedule expands it, so
//     s_axis_tready stays low after reset until the expansion is done
//   stall: a held m_axis_tready keeps the result in the output register;
//     the round unit finishes the next block and waits for the register
// ----------------------------------------------------------------------------
module simon32_64_block_encrypt_core (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // key register write
    input  logic                          i_cfg_we,
    input  logic [simon_pkg::KEY_W-1:0]   i_cfg_wdata,
    // plaintext request stream
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    input  logic [simon_pkg::BLOCK_W-1:0] s_axis_tdata,   // [31:0] plain_block
    // ciphertext stream
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    output logic [simon_pkg::BLOCK_W-1:0] m_axis_tdata    // [31:0] cipher_block
);

    // key register and schedule kick
    logic [simon_pkg::KEY_W-1:0]    r_key;
    logic                           r_kick;

    // key schedule and key ram
    logic                           ks_busy;
    simon_pkg::t_key_wr             ks_wr;
    logic [simon_pkg::WORD_W-1:0]   ram_rdata;

    // round unit
    logic [simon_pkg::ROUND_AW-1:0] rnd_raddr;
    logic                           rnd_idle;
    logic                           rnd_done;
    logic [simon_pkg::BLOCK_W-1:0]  rnd_result;
    logic                           in_accept;
    logic                           out_take;

    // output register
    logic                           r_out_valid;
    logic [simon_pkg::BLOCK_W-1:0]  r_out_data;

    // key write, schedule starts the cycle after (reset starts it with key zero)
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key  <= '0;
            r_kick <= 1'b1;
        end else begin
            r_kick <= i_cfg_we;
            if (i_cfg_we) begin
                r_key <= i_cfg_wdata;
            end
        end
    end

    simon_key_sched u_key_sched (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_kick),
        .i_key   (r_key),
        .o_busy  (ks_busy),
        .o_wr    (ks_wr)
    );

    // requests wait out expansion; keeping key writes clear of a block in flight is up to the user
    simon_key_ram #(
        .DEPTH (simon_pkg::NUM_ROUNDS),
        .WIDTH (simon_pkg::WORD_W)
    ) u_key_ram (
        .i_clk   (i_clk),
        .i_we    (ks_wr.we),
        .i_waddr (ks_wr.addr),
        .i_wdata (ks_wr.data),
        .i_raddr (rnd_raddr),
        .o_rdata (ram_rdata)
    );

    // accept only with a settled key store and a free round unit
    assign s_axis_tready = rnd_idle && !ks_busy && !r_kick;
    assign in_accept     = s_axis_tvalid && s_axis_tready;

    // move the finished block when the output register is empty or draining
    assign out_take = rnd_done && (!r_out_valid || m_axis_tready);

    simon_round u_round (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (in_accept),
        .i_block   (s_axis_tdata),
        .i_rkey    (ram_rdata),
        .i_take    (out_take),
        .o_rd_addr (rnd_raddr),
        .o_idle    (rnd_idle),
        .o_done    (rnd_done),
        .o_result  (rnd_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_take) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_take) begin
            r_out_data <= rnd_result;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

endmodule

>>> rtl/simon_core_checker.sv
// ----------------------------------------------------------------------------
// simon_core_checker
// port-level checks of the encrypt core, bound to the top level
// ----------------------------------------------------------------------------
module simon_core_checker (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          i_cfg_we,
    input logic                          s_axis_tvalid,
    input logic                          s_axis_tready,
    input logic                          m_axis_tvalid,
    input logic                          m_axis_tready,
    input logic [simon_pkg::BLOCK_W-1:0] m_axis_tdata
);

    // output register empties on reset
    a_rst_out_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("output valid after reset");

    // a stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("stalled result changed");

    // one block in flight: no request right after an accepted one
    a_one_block: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("request taken while a block is in flight");

    // a key write starts the expansion, requests held off
    a_key_block: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cfg_we |=> !s_axis_tready)
        else $error("request possible during key expansion");

    // a new result only comes from a block that was being worked on
    a_result_origin: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(m_axis_tvalid) |-> $past(!s_axis_tready))
        else $error("result appeared without a block in flight");

endmodule

bind simon32_64_block_encrypt_core simon_core_checker u_simon_core_checker (.*);

>>> test/simon_cipher_checker.sv
// ----------------------------------------------------------------------------
// simon_cipher_checker
// follows key writes and plaintext requests, predicts each ciphertext and
// compares it with the block's output stream
// ----------------------------------------------------------------------------
module simon_cipher_checker (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [simon_pkg::KEY_W-1:0]   i_cfg_wdata,
    input  logic                          i_in_valid,
    input  logic                          i_in_ready,
    input  logic [simon_pkg::BLOCK_W-1:0] i_in_data,    // [31:0] plain_block
    input  logic                          i_out_valid,
    input  logic                          i_out_ready,
    input  logic [simon_pkg::BLOCK_W-1:0] i_out_data,   // [31:0] cipher_block
    output int                            o_pending,
    output int                            o_fail_count
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int W      = simon_pkg::WORD_W;
    localparam int ROUNDS = simon_pkg::NUM_ROUNDS;
    localparam int KWORDS = simon_pkg::KEY_WORDS;

    // z0 sequence, element 0 in bit 0, period 31
    localparam logic [30:0]  Z0_BITS    = 31'b0110011100001101010010001011111;
    localparam logic [W-1:0] SCHED_MASK = 16'hFFFC;

    logic [W-1:0]                  sched_key [ROUNDS];
    logic [simon_pkg::BLOCK_W-1:0] cipher_q [$];
    int                            fails = 0;

    function automatic logic [W-1:0] spin_left(input logic [W-1:0] v, input int n);
        logic [2*W-1:0] dbl;
        dbl = {v, v} << n;
        return dbl[2*W-1 -: W];
    endfunction

    task automatic expand_schedule(input logic [simon_pkg::KEY_W-1:0] key);
        logic [W-1:0] t;
        for (int i = 0; i < ROUNDS; i++) begin
            if (i < KWORDS) begin
                sched_key[i] = key[W*i +: W];
            end else begin
                t = spin_left(sched_key[i-1], W - 3) ^ sched_key[i-3];
                t = t ^ spin_left(t, W - 1);
                sched_key[i] = sched_key[i-4] ^ SCHED_MASK ^ t
                             ^ W'(Z0_BITS[(i - KWORDS) % 31]);
            end
        end
    endtask

    function automatic logic [simon_pkg::BLOCK_W-1:0] encrypt_block(
            input logic [simon_pkg::BLOCK_W-1:0] plain);
        logic [W-1:0] x;
        logic [W-1:0] y;
        logic [W-1:0] t;
        x = plain[2*W-1:W];
        y = plain[W-1:0];
        for (int i = 0; i < ROUNDS; i++) begin
            t = x;
            x = y ^ (spin_left(x, 1) & spin_left(x, 8)) ^ spin_left(x, 2) ^ sched_key[i];
            y = t;
        end
        return {x, y};
    endfunction

    always @(posedge i_clk) begin : monitor
        logic [simon_pkg::BLOCK_W-1:0] want;
        if (!i_rst_n) begin
            expand_schedule('0);
            cipher_q.delete();
        end else begin
            if (i_cfg_we) begin
                expand_schedule(i_cfg_wdata);
            end
            if (i_out_valid && i_out_ready) begin
                if (cipher_q.size() == 0) begin
                    fails++;
                    $display("%0t: ciphertext %08h with no request outstanding",
                             $realtime, i_out_data);
                end else begin
                    want = cipher_q.pop_front();
                    if (want !== i_out_data) begin
                        fails++;
                        $display("%0t: cipher_block expected %08h actual %08h",
                                 $realtime, want, i_out_data);
                    end
                end
            end
            if (i_in_valid && i_in_ready) begin
                cipher_q.push_back(encrypt_block(i_in_data));
            end
        end
        o_pending    <= cipher_q.size();
        o_fail_count <= fails;
    end

endmodule

>>> test/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// drives keys and plaintext requests into the simon32/64 encrypt core with
// random gaps and output stalls; a checker beside it predicts and compares
// ----------------------------------------------------------------------------
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    // watchdog limit on the length of the whole run
    localparam int CYCLE_LIMIT = 400000;
    localparam int DRAIN_WAIT  = 40;

    logic                          i_clk         = 1'b0;
    logic                          i_rst_n       = 1'b0;
    logic                          i_cfg_we      = 1'b0;
    logic [simon_pkg::KEY_W-1:0]   i_cfg_wdata   = '0;
    logic                          s_axis_tvalid = 1'b0;
    logic                          s_axis_tready;
    logic [simon_pkg::BLOCK_W-1:0] s_axis_tdata  = '0;   // [31:0] plain_block
    logic                          m_axis_tvalid;
    logic                          m_axis_tready = 1'b0;
    logic [simon_pkg::BLOCK_W-1:0] m_axis_tdata;         // [31:0] cipher_block

    int pending_count;
    int fail_count;
    int cycle_count = 0;

    // per phase: no sender gaps / no receiver stalls
    bit tx_no_gap = 1'b0;
    bit rx_no_stall = 1'b0;

    always #10 i_clk = ~i_clk;

    simon32_64_block_encrypt_core u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    simon_cipher_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_wdata  (i_cfg_wdata),
        .i_in_valid   (s_axis_tvalid),
        .i_in_ready   (s_axis_tready),
        .i_in_data    (s_axis_tdata),
        .i_out_valid  (m_axis_tvalid),
        .i_out_ready  (m_axis_tready),
        .i_out_data   (m_axis_tdata),
        .o_pending    (pending_count),
        .o_fail_count (fail_count)
    );

    // watchdog
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("simon32_64_block_encrypt_core verification failed");
            $finish;
        end
    end

    // output side: random stall before each result, held high in no-stall phases
    initial begin : result_sink
        int stall;
        forever begin
            stall = rx_no_stall ? 0 : $urandom_range(0, 15);
            if (stall > 0) begin
                m_axis_tready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            m_axis_tready <= 1'b1;
            @(posedge i_clk);
            while (!m_axis_tvalid) @(posedge i_clk);
        end
    end

    // one plaintext request, after a random gap; returns at the accepting edge
    task automatic send_block(input logic [simon_pkg::BLOCK_W-1:0] plain);
        int gap;
        gap = tx_no_gap ? 0 : $urandom_range(0, 15);
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= plain;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
    endtask

    // stop sending and wait until every ciphertext has come back
    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pending_count != 0) @(posedge i_clk);
    endtask

    // one-cycle key write, only while the core is idle
    task automatic write_key(input logic [simon_pkg::KEY_W-1:0] key);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= key;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
    endtask

    // mostly full random blocks, now and then an extreme or a one-hot pattern
    function automatic logic [simon_pkg::BLOCK_W-1:0] pick_block();
        logic [simon_pkg::BLOCK_W-1:0] v;
        case ($urandom_range(0, 11))
            0: v = '0;
            1: v = '1;
            2: v = 32'h1 << $urandom_range(0, 31);
            default: v = $urandom;
        endcase
        return v;
    endfunction

    initial begin : stimulus
        logic [simon_pkg::KEY_W-1:0] key;
        int nitems;

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // encryption before any key write uses the all-zero key
        send_block(32'h0000_0000);
        send_block(32'hFFFF_FFFF);
        send_block(32'hFFFF_0000);
        send_block(32'h0000_FFFF);
        send_block(32'h8000_0000);
        send_block(32'h0000_0001);
        send_block(32'hAAAA_AAAA);
        send_block(32'h5555_5555);
        wait_drained();

        // published test vector key and block
        write_key(64'h1918_1110_0908_0100);
        send_block(32'h6565_6877);
        send_block(32'h0000_0000);
        wait_drained();

        // extreme keys
        write_key('1);
        send_block(32'h0000_0000);
        send_block(32'hFFFF_FFFF);
        send_block(32'h1234_5678);
        wait_drained();
        write_key('0);
        send_block(32'hFFFF_FFFF);
        wait_drained();
        write_key(64'hAAAA_AAAA_AAAA_AAAA);
        send_block(32'h5555_AAAA);
        send_block(32'hAAAA_5555);
        wait_drained();
        write_key(64'h5555_5555_5555_5555);
        send_block(32'h0001_8000);
        send_block(32'h8000_0001);
        wait_drained();

        // random phases, each under one key with its own idling mix
        for (int phase = 0; phase < 12; phase++) begin
            case ($urandom_range(0, 5))
                0: key = '0;
                1: key = '1;
                default: key = {$urandom, $urandom};
            endcase
            write_key(key);
            tx_no_gap   = (phase % 3 == 1);
            rx_no_stall = (phase % 4 == 2);
            nitems = 100;
            repeat (nitems) send_block(pick_block());
            wait_drained();
            tx_no_gap   = 1'b0;
            rx_no_stall = 1'b0;
        end

        // catch any late or extra ciphertext
        repeat (DRAIN_WAIT) @(posedge i_clk);

        if (fail_count == 0) begin
            $display("simon32_64_block_encrypt_core verification clean");
        end else begin
            $display("simon32_64_block_encrypt_core verification failed");
        end
        $finish;
    end

endmodule
